// ----- src/assert_macros.svh -----
// assertion macros used by the tracker rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/arqsw_pkg.sv -----
// types and constants of the resend window tracker
package arqsw_pkg;

	localparam int FUNC_W      = 2;
	localparam int KIND_W      = 2;
	localparam int SEQ_OUT_W   = 4;
	localparam int ACK_W       = 4;
	localparam int HANDLE_W    = 16;
	localparam int TIME_W      = 16;
	localparam int MAX_RESULTS = 9;
	localparam int MAX_RESEND  = MAX_RESULTS - 1;
	localparam int RES_CNT_W   = $clog2(MAX_RESEND + 1);

	localparam logic [TIME_W-1:0] TIMEOUT_RST = 16'd100;

	typedef enum logic [FUNC_W-1:0] {
		FN_SEND = 2'd0,
		FN_ACK  = 2'd1,
		FN_TICK = 2'd2,
		FN_NOP  = 2'd3
	} func_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NEW     = 2'd0,
		KIND_RESEND  = 2'd1,
		KIND_STATUS  = 2'd2,
		KIND_REFUSED = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_CLOSE
	} state_t;

endpackage

// ----- src/arqsw_ram.sv -----
// generic single-write, single-read ram with registered read data
module arqsw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/arq_sender_window_tracker.sv -----
// top level of the selective-repeat sender window tracker
// A send, acknowledgement or no-op input puts its single result into the
// result register once the output is free, and only then returns to idle to
// take the next input.
// A tick scans the slots, one slot a cycle unless it waits on a stalled result
// output; a pending slot, while fewer than MAX_RESEND resends were made in
// this tick, adds a read of its stamp and handle from the slot memory, whose
// read data is registered. If every slot is acknowledged the scan is skipped,
// and a tick ends with one status result. The result register lets an input be
// taken while the previous result still waits on the output.
`include "assert_macros.svh"

module arq_sender_window_tracker #(
	parameter int WINDOW_SIZE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [3:0]  ack_seq,
	input  logic [15:0] frame_handle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [3:0]  seq_out,
	output logic [15:0] handle_out,
	output logic        window_flipped,
	output logic        upper_half,
	output logic        last,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int SLOT_W    = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int CNT_W     = $clog2(WINDOW_SIZE + 1);
	localparam int SEQ_W     = $clog2(2 * WINDOW_SIZE);
	localparam int AW        = (SEQ_W + 1 > 5) ? SEQ_W + 1 : 5;
	localparam int TIME_W    = arqsw_pkg::TIME_W;
	localparam int HANDLE_W  = arqsw_pkg::HANDLE_W;
	localparam int SEQ_OUT_W = arqsw_pkg::SEQ_OUT_W;
	localparam int RES_CNT_W = arqsw_pkg::RES_CNT_W;
	localparam int RAM_W     = TIME_W + HANDLE_W;

	arqsw_pkg::state_t state_q, state_d;

	logic [TIME_W-1:0]      tout_q;
	logic [TIME_W-1:0]      tick_q;
	logic                   half_q;
	logic [CNT_W-1:0]       fill_q;
	logic [WINDOW_SIZE-1:0] pend_q;
	logic [WINDOW_SIZE-1:0] ackd_q;
	logic [CNT_W-1:0]       idx_q;
	logic [RES_CNT_W-1:0]   nres_q;

	arqsw_pkg::func_t       func_q;
	logic [3:0]             ack_q;
	logic [HANDLE_W-1:0]    hdl_q;

	logic                   out_valid_q;
	arqsw_pkg::kind_t       kind_q;
	logic [SEQ_OUT_W-1:0]   seq_q;
	logic [HANDLE_W-1:0]    hdl_out_q;
	logic                   flip_out_q;
	logic                   half_out_q;
	logic                   last_q;

	logic                   in_xfer;
	logic                   out_free;
	logic [SEQ_W-1:0]       base;
	logic [SLOT_W-1:0]      slot_idx;
	logic [SLOT_W-1:0]      fill_slot;
	logic                   full;
	logic [AW-1:0]          ack_ext;
	logic [AW-1:0]          base_ext;
	logic [AW-1:0]          ack_diff;
	logic [SLOT_W-1:0]      ack_slot;
	logic                   in_half;
	logic                   all_acked;

	logic                   ram_we;
	logic                   ram_re;
	logic [SLOT_W-1:0]      ram_waddr;
	logic [RAM_W-1:0]       ram_wdata;
	logic [RAM_W-1:0]       ram_rdata;
	logic [TIME_W-1:0]      rd_time;
	logic [HANDLE_W-1:0]    rd_hdl;
	logic [TIME_W-1:0]      age;
	logic                   overdue;

	logic                   ld;
	arqsw_pkg::kind_t       o_kind;
	logic [SEQ_W-1:0]       o_seq;
	logic [HANDLE_W-1:0]    o_hdl;
	logic                   o_last;
	logic                   send_go;
	logic                   ack_go;
	logic                   flip_go;
	logic                   scan_start;
	logic                   idx_inc;
	logic                   nres_inc;

	assign in_ready  = (state_q == arqsw_pkg::ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign base      = half_q ? SEQ_W'(WINDOW_SIZE) : '0;
	assign slot_idx  = idx_q[SLOT_W-1:0];
	assign fill_slot = fill_q[SLOT_W-1:0];
	assign full      = (fill_q == CNT_W'(WINDOW_SIZE));
	assign all_acked = &ackd_q;

	assign ack_ext   = AW'(ack_q);
	assign base_ext  = AW'(base);
	assign ack_diff  = ack_ext - base_ext;
	assign ack_slot  = ack_diff[SLOT_W-1:0];
	assign in_half   = (ack_ext >= base_ext) && (ack_ext < base_ext + AW'(WINDOW_SIZE));

	assign rd_time   = ram_rdata[RAM_W-1 -: TIME_W];
	assign rd_hdl    = ram_rdata[HANDLE_W-1:0];
	assign age       = tick_q - rd_time;
	assign overdue   = (age > tout_q);

	assign ram_waddr = (state_q == arqsw_pkg::ST_EXEC) ? fill_slot : slot_idx;
	assign ram_wdata = {tick_q, (state_q == arqsw_pkg::ST_EXEC) ? hdl_q : rd_hdl};

	arqsw_ram #(
		.WIDTH(RAM_W),
		.DEPTH(WINDOW_SIZE)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(slot_idx),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d    = state_q;
		ld         = 1'b0;
		o_kind     = arqsw_pkg::KIND_STATUS;
		o_seq      = '0;
		o_hdl      = '0;
		o_last     = 1'b1;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		send_go    = 1'b0;
		ack_go     = 1'b0;
		flip_go    = 1'b0;
		scan_start = 1'b0;
		idx_inc    = 1'b0;
		nres_inc   = 1'b0;
		unique case (state_q)
			arqsw_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = arqsw_pkg::ST_EXEC;
				end
			end
			arqsw_pkg::ST_EXEC: begin
				unique case (func_q)
					arqsw_pkg::FN_SEND: begin
						if (out_free) begin
							ld      = 1'b1;
							state_d = arqsw_pkg::ST_IDLE;
							if (full) begin
								o_kind = arqsw_pkg::KIND_REFUSED;
							end else begin
								o_kind  = arqsw_pkg::KIND_NEW;
								o_seq   = base + SEQ_W'(fill_slot);
								o_hdl   = hdl_q;
								ram_we  = 1'b1;
								send_go = 1'b1;
							end
						end
					end
					arqsw_pkg::FN_ACK: begin
						if (out_free) begin
							ld      = 1'b1;
							ack_go  = in_half && pend_q[ack_slot];
							state_d = arqsw_pkg::ST_IDLE;
						end
					end
					arqsw_pkg::FN_TICK: begin
						scan_start = 1'b1;
						state_d    = all_acked ? arqsw_pkg::ST_CLOSE : arqsw_pkg::ST_SCAN_RD;
					end
					default: begin
						if (out_free) begin
							ld      = 1'b1;
							state_d = arqsw_pkg::ST_IDLE;
						end
					end
				endcase
			end
			arqsw_pkg::ST_SCAN_RD: begin
				priority if (idx_q == CNT_W'(WINDOW_SIZE)) begin
					state_d = arqsw_pkg::ST_CLOSE;
				end else if (pend_q[slot_idx] && (nres_q < RES_CNT_W'(arqsw_pkg::MAX_RESEND))) begin
					ram_re  = 1'b1;
					state_d = arqsw_pkg::ST_SCAN_EV;
				end else begin
					idx_inc = 1'b1;
				end
			end
			arqsw_pkg::ST_SCAN_EV: begin
				if (overdue) begin
					if (out_free) begin
						ld       = 1'b1;
						o_kind   = arqsw_pkg::KIND_RESEND;
						o_seq    = base + SEQ_W'(slot_idx);
						o_hdl    = rd_hdl;
						o_last   = 1'b0;
						ram_we   = 1'b1;
						nres_inc = 1'b1;
						idx_inc  = 1'b1;
						state_d  = arqsw_pkg::ST_SCAN_RD;
					end
				end else begin
					idx_inc = 1'b1;
					state_d = arqsw_pkg::ST_SCAN_RD;
				end
			end
			arqsw_pkg::ST_CLOSE: begin
				if (out_free) begin
					ld      = 1'b1;
					flip_go = all_acked;
					state_d = arqsw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = arqsw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arqsw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tout_q      <= arqsw_pkg::TIMEOUT_RST;
			tick_q      <= '0;
			half_q      <= 1'b0;
			fill_q      <= '0;
			pend_q      <= '0;
			ackd_q      <= '0;
			idx_q       <= '0;
			nres_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tout_q <= cfg_wdata;
			end
			if (in_xfer && (arqsw_pkg::func_t'(func) == arqsw_pkg::FN_TICK)) begin
				tick_q <= tick_q + 1'b1;
			end
			if (send_go) begin
				pend_q[fill_slot] <= 1'b1;
				fill_q            <= fill_q + 1'b1;
			end
			if (ack_go) begin
				pend_q[ack_slot] <= 1'b0;
				ackd_q[ack_slot] <= 1'b1;
			end
			if (flip_go) begin
				half_q <= ~half_q;
				fill_q <= '0;
				pend_q <= '0;
				ackd_q <= '0;
			end
			if (scan_start) begin
				idx_q  <= '0;
				nres_q <= '0;
			end
			if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (nres_inc) begin
				nres_q <= nres_q + 1'b1;
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q <= arqsw_pkg::func_t'(func);
			ack_q  <= ack_seq;
			hdl_q  <= frame_handle;
		end
		if (ld) begin
			kind_q     <= o_kind;
			seq_q      <= SEQ_OUT_W'(o_seq);
			hdl_out_q  <= o_hdl;
			flip_out_q <= flip_go;
			half_out_q <= half_q ^ flip_go;
			last_q     <= o_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign seq_out        = seq_q;
	assign handle_out     = hdl_out_q;
	assign window_flipped = flip_out_q;
	assign upper_half     = half_out_q;
	assign last           = last_q;

	`ASSERT_ALWAYS(a_flags_excl, (pend_q & ackd_q) == '0, "slot both pending and acked")
	`ASSERT_ALWAYS(a_fill_max, fill_q <= CNT_W'(WINDOW_SIZE), "fill count beyond window")
	`ASSERT_IMPLY(a_read_pending, ram_re, pend_q[slot_idx], "slot read while not pending")
	`ASSERT_IMPLY(a_resend_cap, nres_inc, nres_q < RES_CNT_W'(arqsw_pkg::MAX_RESEND), "too many resends in one tick")
	`ASSERT_NEXT(a_flip_clears, flip_go, (pend_q == '0) && (ackd_q == '0) && (fill_q == '0), "half switch left slot state")

endmodule

// ----- tb/arq_sender_window_tracker_tb.sv -----
// self-checking testbench for the resend window tracker with random traffic and stalls
module arq_sender_window_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_AT = 90;
	localparam int HOLD_AT = 60;
	localparam int HOLD_LEN = 300;
	localparam int PHASES = 5;
	localparam logic [15:0] PHASE_TIMEOUT [PHASES] = '{16'd0, 16'd1, 16'hffff, 16'd3, 16'd2};
	localparam int PHASE_LEN [PHASES] = '{20, 25, 12, 22, 15};

	typedef enum logic [1:0] {SLOT_FREE, SLOT_PENDING, SLOT_ACKED} slot_t;

	typedef struct packed {
		slot_t [WIN-1:0]       status;
		logic [WIN-1:0][15:0]  stamp;
		logic [WIN-1:0][15:0]  handle;
		logic [4:0]            next_send;
		logic                  upper;
		logic [15:0]           now;
		logic [15:0]           timeout;
	} window_t;

	typedef struct packed {
		arqsw_pkg::func_t func;
		logic [3:0]       ack;
		logic [15:0]      handle;
	} frame_req_t;

	typedef struct packed {
		arqsw_pkg::kind_t kind;
		logic [3:0]       seq;
		logic [15:0]      handle;
		logic             flipped;
		logic             upper;
		logic             last;
	} tx_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = '0;
	logic [3:0]  ack_seq = '0;
	logic [15:0] frame_handle = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [3:0]  seq_out;
	logic [15:0] handle_out;
	logic        window_flipped;
	logic        upper_half;
	logic        last;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	window_t    plan_win;
	window_t    model_win;
	frame_req_t queued_reqs [$];
	tx_result_t due_results [$];
	frame_req_t next_req;
	frame_req_t seen_req;
	tx_result_t want;

	int planned, loaded, accepted, results_seen, errors;
	int n_resend, n_flip, n_refused;
	int gap_left, stall_left, hold_left, cycles;
	bit in_acc, quiet, drain_done, hold_done;

	arq_sender_window_tracker #(.WINDOW_SIZE(WIN)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.ack_seq(ack_seq),
		.frame_handle(frame_handle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.seq_out(seq_out),
		.handle_out(handle_out),
		.window_flipped(window_flipped),
		.upper_half(upper_half),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5ns clk = ~clk;

	function automatic void advance_window(inout window_t w, input frame_req_t r,
			inout tx_result_t q [$]);
		logic [4:0]  base;
		logic [15:0] age;
		int          n;
		bit          all_acked;
		tx_result_t  o;
		tx_result_t  rs;
		base = w.upper ? 5'(WIN) : 5'd0;
		o = '0;
		o.kind = arqsw_pkg::KIND_STATUS;
		o.last = 1'b1;
		case (r.func)
			arqsw_pkg::FN_SEND: begin
				if (w.next_send < base || w.next_send >= base + 5'(WIN)) begin
					o.kind = arqsw_pkg::KIND_REFUSED;
				end else begin
					w.status[w.next_send % WIN] = SLOT_PENDING;
					w.stamp[w.next_send % WIN] = w.now;
					w.handle[w.next_send % WIN] = r.handle;
					o.kind = arqsw_pkg::KIND_NEW;
					o.seq = w.next_send[3:0];
					o.handle = r.handle;
					w.next_send = w.next_send + 5'd1;
				end
			end
			arqsw_pkg::FN_ACK: begin
				if (5'(r.ack) >= base && 5'(r.ack) < base + 5'(WIN)) begin
					if (w.status[5'(r.ack) - base] == SLOT_PENDING)
						w.status[5'(r.ack) - base] = SLOT_ACKED;
				end
			end
			arqsw_pkg::FN_TICK: begin
				w.now = w.now + 16'd1;
				n = 0;
				all_acked = 1'b1;
				for (int i = 0; i < WIN; i++) begin
					if (w.status[i] == SLOT_PENDING) begin
						age = w.now - w.stamp[i];
						if (age > w.timeout && n < arqsw_pkg::MAX_RESEND) begin
							rs = '0;
							rs.kind = arqsw_pkg::KIND_RESEND;
							rs.seq = 4'(base + 5'(i));
							rs.handle = w.handle[i];
							rs.upper = w.upper;
							q.push_back(rs);
							n++;
							w.stamp[i] = w.now;
						end
					end
					if (w.status[i] != SLOT_ACKED)
						all_acked = 1'b0;
				end
				if (all_acked) begin
					w.upper = ~w.upper;
					w.next_send = w.upper ? 5'(WIN) : 5'd0;
					for (int i = 0; i < WIN; i++)
						w.status[i] = SLOT_FREE;
				end
				o.flipped = all_acked;
			end
			default: ;
		endcase
		o.upper = w.upper;
		q.push_back(o);
	endfunction

	task automatic plan(input arqsw_pkg::func_t f, input logic [3:0] a, input logic [15:0] h);
		frame_req_t r;
		tx_result_t scratch [$];
		r.func = f;
		r.ack = a;
		r.handle = h;
		advance_window(plan_win, r, scratch);
		queued_reqs.push_back(r);
		planned++;
	endtask

	// mostly whole window rounds: sends, acks of pending numbers, ticks; some noise
	task automatic plan_random();
		logic [3:0] pend [$];
		logic [4:0] base;
		bit         all_acked;
		int         r;
		base = plan_win.upper ? 5'(WIN) : 5'd0;
		all_acked = 1'b1;
		for (int i = 0; i < WIN; i++) begin
			if (plan_win.status[i] == SLOT_PENDING)
				pend.push_back(4'(base + 5'(i)));
			if (plan_win.status[i] != SLOT_ACKED)
				all_acked = 1'b0;
		end
		r = $urandom_range(0, 99);
		if (all_acked && r < 80)
			plan(arqsw_pkg::FN_TICK, 4'($urandom), 16'($urandom));
		else if (r < 4)
			plan(arqsw_pkg::FN_NOP, 4'($urandom), 16'($urandom));
		else if (r < 14)
			plan(arqsw_pkg::FN_ACK, 4'($urandom_range(0, 15)), 16'($urandom));
		else if (r < 42 && pend.size() > 0)
			plan(arqsw_pkg::FN_ACK, pend[$urandom_range(0, pend.size() - 1)], 16'($urandom));
		else if (r < 72)
			plan(arqsw_pkg::FN_SEND, 4'($urandom), 16'($urandom));
		else
			plan(arqsw_pkg::FN_TICK, 4'($urandom), 16'($urandom));
	endtask

	task automatic wait_idle();
		while (accepted != planned || due_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("mismatch on %s at result %0d: got %0h, want %0h",
			what, results_seen, got, exp_val);
		errors++;
	endtask

	function automatic int draw_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if ($urandom_range(0, 199) == 0)
			quiet <= ~quiet;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// sender
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_acc)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left = gap_left - 1;
			end else if (loaded == DRAIN_AT && !drain_done) begin
				in_valid <= 1'b0;
				if (accepted == loaded && due_results.size() == 0)
					drain_done = 1'b1;
			end else if (queued_reqs.size() > 0) begin
				next_req = queued_reqs.pop_front();
				in_valid <= 1'b1;
				func <= next_req.func;
				ack_seq <= next_req.ack;
				frame_handle <= next_req.handle;
				loaded++;
				gap_left = draw_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = draw_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result kind", int'(kind), 0);
				end else begin
					want = due_results.pop_front();
					if (kind != want.kind)
						report_mismatch("kind", int'(kind), int'(want.kind));
					if (seq_out != want.seq)
						report_mismatch("seq_out", int'(seq_out), int'(want.seq));
					if (handle_out != want.handle)
						report_mismatch("handle_out", int'(handle_out), int'(want.handle));
					if (window_flipped != want.flipped)
						report_mismatch("window_flipped", int'(window_flipped),
							int'(want.flipped));
					if (upper_half != want.upper)
						report_mismatch("upper_half", int'(upper_half), int'(want.upper));
					if (last != want.last)
						report_mismatch("last", int'(last), int'(want.last));
					if (want.kind == arqsw_pkg::KIND_RESEND)
						n_resend++;
					if (want.kind == arqsw_pkg::KIND_REFUSED)
						n_refused++;
					if (want.flipped)
						n_flip++;
				end
			end
			in_acc <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				seen_req.func = arqsw_pkg::func_t'(func);
				seen_req.ack = ack_seq;
				seen_req.handle = frame_handle;
				advance_window(model_win, seen_req, due_results);
				accepted++;
			end
		end
	end

	initial begin
		plan_win = '0;
		plan_win.timeout = arqsw_pkg::TIMEOUT_RST;
		model_win = plan_win;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// lower half filled, refused, stray and repeated acks, full ack then switch
		plan(arqsw_pkg::FN_NOP, 4'hf, 16'hffff);
		plan(arqsw_pkg::FN_ACK, 4'd0, 16'($urandom));
		plan(arqsw_pkg::FN_TICK, 4'($urandom), 16'($urandom));
		plan(arqsw_pkg::FN_SEND, 4'($urandom), 16'h0000);
		plan(arqsw_pkg::FN_SEND, 4'($urandom), 16'hffff);
		for (int i = 0; i < WIN - 2; i++)
			plan(arqsw_pkg::FN_SEND, 4'($urandom), 16'($urandom));
		plan(arqsw_pkg::FN_SEND, 4'($urandom), 16'($urandom));
		plan(arqsw_pkg::FN_ACK, 4'd15, 16'($urandom));
		plan(arqsw_pkg::FN_ACK, 4'd0, 16'($urandom));
		plan(arqsw_pkg::FN_ACK, 4'd0, 16'($urandom));
		plan(arqsw_pkg::FN_TICK, 4'($urandom), 16'($urandom));
		for (int i = 1; i < WIN; i++)
			plan(arqsw_pkg::FN_ACK, 4'(i), 16'($urandom));
		plan(arqsw_pkg::FN_TICK, 4'($urandom), 16'($urandom));
		plan(arqsw_pkg::FN_SEND, 4'($urandom), 16'($urandom));
		plan(arqsw_pkg::FN_ACK, 4'd3, 16'($urandom));

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			repeat (4) @(negedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= PHASE_TIMEOUT[p];
			plan_win.timeout = PHASE_TIMEOUT[p];
			model_win.timeout = PHASE_TIMEOUT[p];
			@(negedge clk);
			cfg_we <= 1'b0;
			repeat (PHASE_LEN[p]) plan_random();
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("%0d input transfers over %0d timeout settings, %0d results checked",
			accepted, PHASES + 1, results_seen);
		$display("%0d resends, %0d half switches, %0d refused sends, %0d mismatches",
			n_resend, n_flip, n_refused, errors);
		if (errors == 0 && due_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
